>>> hw/rtl/dvru_pkg.sv
package dvru_pkg;

    // fixed field widths of the channels
    localparam int OPCODE_BITS    = 2;
    localparam int IDX_BITS       = 2;
    localparam int FIELD_COST_BITS = 16;
    localparam int MASK_BITS      = 4;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 4;

    localparam logic [OPCODE_BITS-1:0] OP_WRITE   = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_COMPUTE = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_READ    = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_OWN_NODE      = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NEIGHBOR_MASK = 2'd1;

    typedef enum logic [1:0] {
        ADDR_ITEM,
        ADDR_OWN_COL,
        ADDR_OWN_K,
        ADDR_K_COL
    } addr_sel_t;

    typedef struct packed {
        logic      capture_item;
        logic      write_item;
        logic      rd_issue;
        addr_sel_t addr_sel;
        logic      load_best;
        logic      load_a;
        logic      relax;
        logic      write_best;
        logic      col_clear;
        logic      col_inc;
        logic      k_clear;
        logic      k_inc;
        logic      load_out_item;
        logic      load_out_row;
    } dvru_cmd_t;

    typedef struct packed {
        logic own_ok;
        logic col_is_own;
        logic col_last;
        logic k_is_nbr;
        logic k_last;
    } dvru_status_t;

endpackage

>>> hw/rtl/dvru_in_if.sv
interface dvru_in_if;
    import dvru_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OPCODE_BITS-1:0]     opcode;
    logic [IDX_BITS-1:0]        row_index;
    logic [IDX_BITS-1:0]        col_index;
    logic [FIELD_COST_BITS-1:0] cost_value;
    logic                       cost_unreachable;

    modport source (
        output valid, opcode, row_index, col_index, cost_value, cost_unreachable,
        input  ready
    );
    modport sink (
        input  valid, opcode, row_index, col_index, cost_value, cost_unreachable,
        output ready
    );
endinterface

>>> hw/rtl/dvru_out_if.sv
interface dvru_out_if;
    import dvru_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [IDX_BITS-1:0]        out_column;
    logic [FIELD_COST_BITS-1:0] out_cost;
    logic                       out_unreachable;
    logic                       last_result;

    modport source (
        output valid, out_column, out_cost, out_unreachable, last_result,
        input  ready
    );
    modport sink (
        input  valid, out_column, out_cost, out_unreachable, last_result,
        output ready
    );
endinterface

>>> hw/rtl/dvru_cfg_if.sv
interface dvru_cfg_if;
    import dvru_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/distance_vector_route_update.sv
// Distance-vector route table of NODES x NODES link costs, each either a
// COST_BITS cost or unreachable, held in a single-port table with one valid
// flop per entry (all unreachable right after reset, no clearing pass).
// A write transaction returns nothing; a read transaction returns one result
// once its entry is read and the output register is free. A recompute
// transaction relaxes the own row in place, column by column, and then returns
// the whole row, last_result set on the final column; with own_node out of
// range it returns nothing. Every table access goes through the one memory
// port. One transaction is processed at a time; a finished result waits in
// the output register while the next input is taken.
// Configuration is accepted in every cycle: index 0 own_node, 1 neighbor_mask.
module distance_vector_route_update #(
    parameter int NODES     = 4,
    parameter int COST_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    dvru_in_if.sink           in_ch,
    dvru_out_if.source        out_ch,
    dvru_cfg_if.sink          cfg_ch
);
    import dvru_pkg::*;

    dvru_cmd_t    cmd;
    dvru_status_t status;

    assign cfg_ch.ready = 1'b1;

    dvru_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_opcode (in_ch.opcode),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    dvru_datapath #(
        .NODES     (NODES),
        .COST_BITS (COST_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .row_index        (in_ch.row_index),
        .col_index        (in_ch.col_index),
        .cost_value       (in_ch.cost_value),
        .cost_unreachable (in_ch.cost_unreachable),
        .cfg_we           (cfg_ch.valid),
        .cfg_index        (cfg_ch.index),
        .cfg_data         (cfg_ch.data),
        .out_column       (out_ch.out_column),
        .out_cost         (out_ch.out_cost),
        .out_unreachable  (out_ch.out_unreachable),
        .last_result      (out_ch.last_result)
    );

endmodule

>>> hw/rtl/dvru_ctrl.sv
module dvru_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [dvru_pkg::OPCODE_BITS-1:0] in_opcode,
    output logic                         out_valid,
    input  logic                         out_ready,
    input  dvru_pkg::dvru_status_t       status,
    output dvru_pkg::dvru_cmd_t          cmd
);
    import dvru_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RD_ADDR = 4'd1;
    localparam logic [3:0] S_RD_OUT  = 4'd2;
    localparam logic [3:0] S_COL     = 4'd3;
    localparam logic [3:0] S_BEST    = 4'd4;
    localparam logic [3:0] S_NBR     = 4'd5;
    localparam logic [3:0] S_A       = 4'd6;
    localparam logic [3:0] S_B       = 4'd7;
    localparam logic [3:0] S_WB      = 4'd8;
    localparam logic [3:0] S_EM_ADDR = 4'd9;
    localparam logic [3:0] S_EM_OUT  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.addr_sel = ADDR_ITEM;
        state_next   = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_opcode)
                        OP_WRITE:
                        begin
                            cmd.write_item = 1'b1;
                        end
                        OP_READ:
                        begin
                            cmd.capture_item = 1'b1;
                            state_next       = S_RD_ADDR;
                        end
                        OP_COMPUTE:
                        begin
                            if (status.own_ok)
                            begin
                                cmd.col_clear = 1'b1;
                                state_next    = S_COL;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD_ADDR:
            begin
                cmd.addr_sel = ADDR_ITEM;
                cmd.rd_issue = 1'b1;
                state_next   = S_RD_OUT;
            end
            S_RD_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out_item = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            S_COL:
            begin
                if (status.col_is_own)
                begin
                    // own column keeps its value
                    if (status.col_last)
                    begin
                        cmd.col_clear = 1'b1;
                        state_next    = S_EM_ADDR;
                    end
                    else
                    begin
                        cmd.col_inc = 1'b1;
                    end
                end
                else
                begin
                    cmd.addr_sel = ADDR_OWN_COL;
                    cmd.rd_issue = 1'b1;
                    state_next   = S_BEST;
                end
            end
            S_BEST:
            begin
                cmd.load_best = 1'b1;
                cmd.k_clear   = 1'b1;
                state_next    = S_NBR;
            end
            S_NBR:
            begin
                if (status.k_is_nbr)
                begin
                    cmd.addr_sel = ADDR_OWN_K;
                    cmd.rd_issue = 1'b1;
                    state_next   = S_A;
                end
                else if (status.k_last)
                begin
                    state_next = S_WB;
                end
                else
                begin
                    cmd.k_inc = 1'b1;
                end
            end
            S_A:
            begin
                cmd.load_a   = 1'b1;
                cmd.addr_sel = ADDR_K_COL;
                cmd.rd_issue = 1'b1;
                state_next   = S_B;
            end
            S_B:
            begin
                cmd.relax = 1'b1;
                if (status.k_last)
                begin
                    state_next = S_WB;
                end
                else
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = S_NBR;
                end
            end
            S_WB:
            begin
                cmd.addr_sel   = ADDR_OWN_COL;
                cmd.write_best = 1'b1;
                if (status.col_last)
                begin
                    cmd.col_clear = 1'b1;
                    state_next    = S_EM_ADDR;
                end
                else
                begin
                    cmd.col_inc = 1'b1;
                    state_next  = S_COL;
                end
            end
            S_EM_ADDR:
            begin
                cmd.addr_sel = ADDR_OWN_COL;
                cmd.rd_issue = 1'b1;
                state_next   = S_EM_OUT;
            end
            S_EM_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out_row = 1'b1;
                    if (status.col_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.col_inc = 1'b1;
                        state_next  = S_EM_ADDR;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out_item || cmd.load_out_row)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_opcode == OP_READ && !out_valid_reg) |-> ##3 out_valid_reg)
        else $error("read result not presented on time");

    a_b_after_a: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_B) |-> ($past(state_reg) == S_A))
        else $error("second leg read without first leg");

    a_bad_own_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_opcode == OP_COMPUTE && !status.own_ok) |=> (state_reg == S_IDLE))
        else $error("recompute started for own node out of range");

endmodule

>>> hw/rtl/dvru_datapath.sv
module dvru_datapath #(
    parameter int NODES     = 4,
    parameter int COST_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dvru_pkg::dvru_cmd_t                  cmd,
    output dvru_pkg::dvru_status_t               status,
    input  logic [dvru_pkg::IDX_BITS-1:0]        row_index,
    input  logic [dvru_pkg::IDX_BITS-1:0]        col_index,
    input  logic [dvru_pkg::FIELD_COST_BITS-1:0] cost_value,
    input  logic                                 cost_unreachable,
    input  logic                                 cfg_we,
    input  logic [dvru_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [dvru_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output logic [dvru_pkg::IDX_BITS-1:0]        out_column,
    output logic [dvru_pkg::FIELD_COST_BITS-1:0] out_cost,
    output logic                                 out_unreachable,
    output logic                                 last_result
);
    import dvru_pkg::*;

    localparam int DEPTH = NODES * NODES;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(NODES);

    typedef struct packed {
        logic                 reach;
        logic [COST_BITS-1:0] cost;
    } entry_t;

    function automatic logic [AW-1:0] addr_of(input logic [31:0] r, input logic [31:0] c);
        return AW'(r * NODES + c);
    endfunction

    entry_t               mem [DEPTH];
    logic [DEPTH-1:0]     valid_reg;
    entry_t               rd_data_reg;
    logic                 rd_valid_reg;
    entry_t               rd_entry;

    logic [IDX_BITS-1:0]  own_reg;
    logic [MASK_BITS-1:0] mask_reg;
    logic [NODES-1:0]     nbr_vec;
    logic [IW-1:0]        own_idx;

    logic [IDX_BITS-1:0]  item_row_reg;
    logic [IDX_BITS-1:0]  item_col_reg;
    logic                 item_ok_reg;
    logic                 item_ok;

    logic [IW-1:0]        col_reg;
    logic [IW-1:0]        k_reg;
    entry_t               best_reg;
    entry_t               a_reg;

    logic [COST_BITS:0]   sum_wide;
    logic [COST_BITS-1:0] sum_sat;
    logic                 take;

    logic [AW-1:0]        raddr;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        own_col_addr;
    logic                 mem_we;
    entry_t               wdata;

    logic [IDX_BITS-1:0]        out_column_reg;
    logic [FIELD_COST_BITS-1:0] out_cost_reg;
    logic                       out_unreachable_reg;
    logic                       last_result_reg;

    genvar g;
    generate
        for (g = 0; g < NODES; g++)
        begin : g_nbr
            if (g < MASK_BITS)
            begin : g_in
                assign nbr_vec[g] = mask_reg[g];
            end
            else
            begin : g_out
                assign nbr_vec[g] = 1'b0;
            end
        end
    endgenerate

    assign own_idx = IW'(own_reg);
    assign item_ok = (32'(row_index) < NODES) && (32'(col_index) < NODES);

    assign status.own_ok     = (32'(own_reg) < NODES);
    assign status.col_is_own = (col_reg == own_idx);
    assign status.col_last   = (col_reg == IW'(NODES - 1));
    assign status.k_is_nbr   = nbr_vec[k_reg];
    assign status.k_last     = (k_reg == IW'(NODES - 1));

    assign own_col_addr = addr_of(32'(own_idx), 32'(col_reg));

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_ITEM:    raddr = addr_of(32'(item_row_reg), 32'(item_col_reg));
            ADDR_OWN_COL: raddr = own_col_addr;
            ADDR_OWN_K:   raddr = addr_of(32'(own_idx), 32'(k_reg));
            ADDR_K_COL:   raddr = addr_of(32'(k_reg), 32'(col_reg));
            default:      raddr = own_col_addr;
        endcase
    end

    always_comb
    begin
        mem_we = cmd.write_best || (cmd.write_item && item_ok);
        if (cmd.write_item)
        begin
            waddr       = addr_of(32'(row_index), 32'(col_index));
            wdata.reach = !cost_unreachable;
            wdata.cost  = cost_unreachable ? '0 : COST_BITS'(cost_value);
        end
        else
        begin
            waddr = own_col_addr;
            wdata = best_reg;
        end
    end

    // entries never written since reset read as unreachable, cost 0
    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (cmd.rd_issue)
            begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    // relax: a_reg holds own-to-neighbor, rd_entry neighbor-to-target
    assign sum_wide = {1'b0, a_reg.cost} + {1'b0, rd_entry.cost};
    assign sum_sat  = sum_wide[COST_BITS] ? '1 : sum_wide[COST_BITS-1:0];
    assign take     = a_reg.reach && rd_entry.reach &&
                      (!best_reg.reach || (sum_sat < best_reg.cost));

    always_ff @(posedge clk)
    begin
        if (cmd.load_best)
        begin
            best_reg <= rd_entry;
        end
        else if (cmd.relax && take)
        begin
            best_reg.reach <= 1'b1;
            best_reg.cost  <= sum_sat;
        end
        if (cmd.load_a)
        begin
            a_reg <= rd_entry;
        end
        if (cmd.capture_item)
        begin
            item_row_reg <= row_index;
            item_col_reg <= col_index;
            item_ok_reg  <= item_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_reg  <= '0;
            mask_reg <= '0;
            col_reg  <= '0;
            k_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_OWN_NODE:      own_reg  <= cfg_data[IDX_BITS-1:0];
                    CFG_NEIGHBOR_MASK: mask_reg <= cfg_data[MASK_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.col_clear)
            begin
                col_reg <= '0;
            end
            else if (cmd.col_inc)
            begin
                col_reg <= col_reg + 1'b1;
            end
            if (cmd.k_clear)
            begin
                k_reg <= '0;
            end
            else if (cmd.k_inc)
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out_item)
        begin
            out_column_reg      <= item_col_reg;
            out_unreachable_reg <= !(item_ok_reg && rd_entry.reach);
            out_cost_reg        <= (item_ok_reg && rd_entry.reach) ?
                                   FIELD_COST_BITS'(rd_entry.cost) : '0;
            last_result_reg     <= 1'b1;
        end
        else if (cmd.load_out_row)
        begin
            out_column_reg      <= IDX_BITS'(col_reg);
            out_unreachable_reg <= !rd_entry.reach;
            out_cost_reg        <= rd_entry.reach ? FIELD_COST_BITS'(rd_entry.cost) : '0;
            last_result_reg     <= status.col_last;
        end
    end

    assign out_column      = out_column_reg;
    assign out_cost        = out_cost_reg;
    assign out_unreachable = out_unreachable_reg;
    assign last_result     = last_result_reg;

    a_relax_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.relax && best_reg.reach) |=>
            (best_reg.reach && best_reg.cost <= $past(best_reg.cost)))
        else $error("relaxation made the best path worse");

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && cmd.rd_issue))
        else $error("table read and write in the same cycle");

    a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> valid_reg[$past(waddr)])
        else $error("written entry not marked valid");

endmodule
